// ===== rtl/fbsc_pkg.sv =====
// fbsc_pkg: shared constants and types for the frustum box/sphere cull block
// no dependencies; imported by every module under rtl
`timescale 1ns / 1ps

package fbsc_pkg;

    // plane register layout: a, b, c signed Q1.14 in the low three 16-bit fields, d Q8.8 on top
    localparam int NUM_PLANES  = 6;
    localparam int PLANE_W     = 64;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int D_TERM_W    = COEF_W + COEF_FRAC;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_DATA_W  = 8;

    // test selector carried in tuser
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // result codes
    typedef enum logic [1:0] {
        CLASS_OUTSIDE   = 2'd0,
        CLASS_INSIDE    = 2'd1,
        CLASS_INTERSECT = 2'd2
    } fbsc_class_t;

    // per-stage load strobes driven by the top-level pipeline control
    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
    } fbsc_ld_t;

endpackage

// ===== rtl/fbsc_plane.sv =====
// fbsc_plane: three-stage signed distance test of one item against one plane
// depends on fbsc_pkg (load strobes, coefficient layout, kind codes)
`timescale 1ns / 1ps

module fbsc_plane #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     clk,
    input  fbsc_pkg::fbsc_ld_t                       ld,
    input  logic                                     kind,
    input  logic [2:0][COORD_WIDTH-1:0]              box_min,
    input  logic [2:0][COORD_WIDTH-1:0]              box_max,
    input  logic [2:0][COORD_WIDTH-1:0]              center,
    input  logic [COORD_WIDTH-2:0]                   radius,
    input  logic [fbsc_pkg::PLANE_W-1:0]             plane,
    output logic                                     far_neg,
    output logic                                     near_neg
);
    import fbsc_pkg::*;

    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int ACC_W  = ((PROD_W > D_TERM_W) ? PROD_W : D_TERM_W) + 4;

    logic [2:0][COORD_WIDTH-1:0] far_next;
    logic [2:0][COORD_WIDTH-1:0] near_next;
    logic [2:0][COORD_WIDTH-1:0] far_reg;
    logic [2:0][COORD_WIDTH-1:0] near_reg;
    logic [ACC_W-1:0]            d_term;
    logic [ACC_W-1:0]            rad_term;
    logic [ACC_W-1:0]            off_next;
    logic [ACC_W-1:0]            off_s0_reg;
    logic [ACC_W-1:0]            off_s1_reg;
    logic [2:0][PROD_W-1:0]      prod_far_next;
    logic [2:0][PROD_W-1:0]      prod_near_next;
    logic [2:0][PROD_W-1:0]      prod_far_reg;
    logic [2:0][PROD_W-1:0]      prod_near_reg;
    logic [ACC_W-1:0]            sum_far;
    logic [ACC_W-1:0]            sum_near;
    logic                        far_neg_reg;
    logic                        near_neg_reg;

    // d and radius scaled to the product grid (2^22)
    assign d_term   = {{(ACC_W-D_TERM_W){plane[PLANE_W-1]}},
                       plane[PLANE_W-1 -: COEF_W], {COEF_FRAC{1'b0}}};
    assign rad_term = {{(ACC_W-COORD_WIDTH-COEF_FRAC+1){1'b0}}, radius, {COEF_FRAC{1'b0}}};

    // stage 0: pick far and near vertex from the normal sign bits; a sphere uses its center and adds its radius to d
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (plane[COEF_W*k + COEF_W-1])
            begin
                far_next[k]  = box_min[k];
                near_next[k] = box_max[k];
            end
            else
            begin
                far_next[k]  = box_max[k];
                near_next[k] = box_min[k];
            end
            if (kind == KIND_SPHERE)
            begin
                far_next[k] = center[k];
            end
        end
        off_next = (kind == KIND_SPHERE) ? (d_term + rad_term) : d_term;
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld0)
        begin
            far_reg    <= far_next;
            near_reg   <= near_next;
            off_s0_reg <= off_next;
        end
    end

    // stage 1: six coefficient products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_far_next[k]  = $signed(far_reg[k])  * $signed(plane[COEF_W*k +: COEF_W]);
            prod_near_next[k] = $signed(near_reg[k]) * $signed(plane[COEF_W*k +: COEF_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld1)
        begin
            prod_far_reg  <= prod_far_next;
            prod_near_reg <= prod_near_next;
            off_s1_reg    <= off_s0_reg;
        end
    end

    // stage 2: full-precision sums, keep only the sign
    always_comb
    begin
        sum_far  = off_s1_reg;
        sum_near = d_term;
        for (int k = 0; k < 3; k++)
        begin
            sum_far  = sum_far  + {{(ACC_W-PROD_W){prod_far_reg[k][PROD_W-1]}},
                                   prod_far_reg[k]};
            sum_near = sum_near + {{(ACC_W-PROD_W){prod_near_reg[k][PROD_W-1]}},
                                   prod_near_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld2)
        begin
            far_neg_reg  <= sum_far[ACC_W-1];
            near_neg_reg <= sum_near[ACC_W-1];
        end
    end

    assign far_neg  = far_neg_reg;
    assign near_neg = near_neg_reg;

endmodule

// ===== rtl/fbsc_classify.sv =====
// fbsc_classify: final stage that merges the six plane signs into one class
// depends on fbsc_pkg (class codes, kind codes, plane count)
`timescale 1ns / 1ps

module fbsc_classify (
    input  logic                                  clk,
    input  logic                                  ld,
    input  logic                                  kind,
    input  logic [fbsc_pkg::NUM_PLANES-1:0]       far_neg,
    input  logic [fbsc_pkg::NUM_PLANES-1:0]       near_neg,
    output fbsc_pkg::fbsc_class_t                 cull_class
);
    import fbsc_pkg::*;

    fbsc_class_t class_next;
    fbsc_class_t class_reg;

    // outside wins, then a box straddling a plane
    always_comb
    begin
        if (|far_neg)
        begin
            class_next = CLASS_OUTSIDE;
        end
        else if ((kind == KIND_BOX) && (|near_neg))
        begin
            class_next = CLASS_INTERSECT;
        end
        else
        begin
            class_next = CLASS_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            class_reg <= class_next;
        end
    end

    assign cull_class = class_reg;

endmodule

// ===== rtl/frustum_box_sphere_cull.sv =====
// frustum_box_sphere_cull: top level, skid buffer, plane registers, pipeline control
// depends on fbsc_pkg, fbsc_plane, fbsc_classify
//
//  channel | signals                              | moves
//  --------+--------------------------------------+-----------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser    | one box or sphere per transfer
//  m       | m_tvalid m_tready m_tdata            | one cull class per transfer
//  cfg     | cfg_we cfg_index cfg_data            | one plane register per write
//
// an accepted item passes through four register stages, vertex pick, products, signs and
// class, and also through the skid register when stage 0 cannot take it; one item per cycle
// sustained while m_tready stays high
// each stage advances whenever the stage after it is empty or moving, so bubbles close
// s_tready comes from a one-entry skid register and never depends on m_tready
// rst_n clears the valid bits, the skid and the planes (all planes zero: everything inside)
`timescale 1ns / 1ps

module frustum_box_sphere_cull #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius, zero pad
    input  logic [((10*COORD_WIDTH-1+7)/8)*8-1:0]  s_tdata,
    // kind
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cull_class, zero pad
    output logic [fbsc_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  logic                                   cfg_we,
    input  logic [fbsc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fbsc_pkg::PLANE_W-1:0]           cfg_data
);
    import fbsc_pkg::*;

    localparam int FIELD_W = 10*COORD_WIDTH - 1;

    logic [PLANE_W-1:0]          plane_reg [NUM_PLANES];
    logic                        skid_valid_reg;
    logic [FIELD_W-1:0]          skid_data_reg;
    logic                        skid_kind_reg;
    logic                        src_valid;
    logic [FIELD_W-1:0]          src_data;
    logic                        src_kind;
    logic [2:0][COORD_WIDTH-1:0] box_min;
    logic [2:0][COORD_WIDTH-1:0] box_max;
    logic [2:0][COORD_WIDTH-1:0] center;
    logic [COORD_WIDTH-2:0]      radius;
    logic                        v0_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic                        kind0_reg;
    logic                        kind1_reg;
    logic                        kind2_reg;
    logic                        ready0;
    logic                        ready1;
    logic                        ready2;
    logic                        ready3;
    fbsc_ld_t                    ld;
    logic                        ld3;
    logic [NUM_PLANES-1:0]       far_neg;
    logic [NUM_PLANES-1:0]       near_neg;
    fbsc_class_t                 cull_class;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_INDEX_W'(NUM_PLANES)))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // stage readiness, back to front
    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign ready0 = !v0_reg || ready1;

    // input side: skid entry takes priority over the port
    assign s_tready  = !skid_valid_reg;
    assign src_valid = skid_valid_reg || s_tvalid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata[FIELD_W-1:0];
    assign src_kind  = skid_valid_reg ? skid_kind_reg : s_tuser;

    assign ld.ld0 = src_valid && ready0;
    assign ld.ld1 = v0_reg && ready1;
    assign ld.ld2 = v1_reg && ready2;
    assign ld3    = v2_reg && ready3;

    // skid register catches a transfer that stage 0 cannot take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (ready0)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s_tvalid && !ready0)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && s_tvalid && !ready0)
        begin
            skid_data_reg <= s_tdata[FIELD_W-1:0];
            skid_kind_reg <= s_tuser;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= src_valid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // kind follows the item to the classify stage
    always_ff @(posedge clk)
    begin
        if (ld.ld0)
        begin
            kind0_reg <= src_kind;
        end
        if (ld.ld1)
        begin
            kind1_reg <= kind0_reg;
        end
        if (ld.ld2)
        begin
            kind2_reg <= kind1_reg;
        end
    end

    // unpack coordinate fields
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            box_min[k] = src_data[COORD_WIDTH*k       +: COORD_WIDTH];
            box_max[k] = src_data[COORD_WIDTH*(k + 3) +: COORD_WIDTH];
            center[k]  = src_data[COORD_WIDTH*(k + 6) +: COORD_WIDTH];
        end
        radius = src_data[COORD_WIDTH*9 +: (COORD_WIDTH-1)];
    end

    // one distance pipeline per plane
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fbsc_plane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane (
            .clk      (clk),
            .ld       (ld),
            .kind     (src_kind),
            .box_min  (box_min),
            .box_max  (box_max),
            .center   (center),
            .radius   (radius),
            .plane    (plane_reg[p]),
            .far_neg  (far_neg[p]),
            .near_neg (near_neg[p])
        );
    end

    fbsc_classify u_classify (
        .clk        (clk),
        .ld         (ld3),
        .kind       (kind2_reg),
        .far_neg    (far_neg),
        .near_neg   (near_neg),
        .cull_class (cull_class)
    );

    // output side
    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, cull_class};

endmodule
